>>> design/esd_pkg.sv
// Shared types and constants for the escape sequence decoder.
// No dependencies; every other design file except esd_fifo imports this package.
package esd_pkg;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_HASH      = 8'h23;

  localparam logic REG_MARK_ENABLE = 1'b0;
  localparam logic REG_MARKER_BYTE = 1'b1;

  localparam logic [1:0] ESC_LIT  = 2'd0;
  localparam logic [1:0] ESC_HASH = 2'd1;
  localparam logic [1:0] ESC_HEX  = 2'd2;
  localparam logic [1:0] ESC_BAD  = 2'd3;

  typedef struct packed {
    logic       is_end;
    logic [7:0] chr;
    logic       is_backslash;
    logic [1:0] esc_class;
    logic [7:0] esc_val;
    logic       hex_ok;
    logic [3:0] hex_val;
  } class_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       end_flag;
    logic       status;
  } result_t;

endpackage

>>> design/escape_sequence_decoder.sv
// Top level of the escape sequence decoder: front classifier, queue, back state machine.
// Depends on esd_pkg, esd_fifo, esd_front and esd_back.
//
//   channel   handshake        payload
//   input     push / full      opcode, in_char
//   result    pop / empty      byte_valid, out_byte, end_flag, status
//   config    cfg_we           cfg_index, cfg_data
//
// One item per cycle is sustained while the result queue has room; each accepted item is
// registered in the classified-item queue, and the back end then writes any result into
// the result queue, from which the result ports are read.
// Reset (rst, synchronous) empties both queues, clears the registers and returns the
// decoder to normal mode. Holding pop low stalls the back end once the result queue fills,
// and the input side stalls only when the classified-item queue is full as well.
module escape_sequence_decoder
  import esd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2,
  parameter int OUT_DEPTH   = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       opcode,
  input  logic [7:0] in_char,
  output logic       empty,
  input  logic       pop,
  output logic       byte_valid,
  output logic [7:0] out_byte,
  output logic       end_flag,
  output logic       status,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic       mark_enable;
  logic [7:0] marker_byte;
  class_t     front_cls;
  class_t     q_cls;
  logic       q_empty;
  logic       out_full;
  logic       item_valid;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_enable <= 1'b0;
      marker_byte <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MARK_ENABLE: mark_enable <= cfg_data[0];
        REG_MARKER_BYTE: marker_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  esd_front u_front (
    .opcode  (opcode),
    .in_char (in_char),
    .cls     (front_cls)
  );

  esd_fifo #(
    .WIDTH ($bits(class_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_cls),
    .full  (full),
    .pop   (item_valid),
    .rdata (q_cls),
    .empty (q_empty)
  );

  assign item_valid = !q_empty && !out_full;

  esd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .mark_enable (mark_enable),
    .marker_byte (marker_byte),
    .item_valid  (item_valid),
    .cls         (q_cls),
    .res_valid   (res_valid),
    .res         (res)
  );

  esd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .wdata (res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign byte_valid = out_res.byte_valid;
  assign out_byte   = out_res.out_byte;
  assign end_flag   = out_res.end_flag;
  assign status     = out_res.status;

endmodule

>>> design/esd_fifo.sv
// Small register queue used between the decoder stages and at the output.
// Generic over width and depth; no package dependencies.
module esd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> design/esd_front.sv
// Front end: classifies each incoming character for the escape decoder.
// Depends on esd_pkg for the classification record and escape codes.
module esd_front
  import esd_pkg::*;
(
  input  logic       opcode,
  input  logic [7:0] in_char,
  output class_t     cls
);

  always_comb begin
    cls              = '0;
    cls.is_end       = opcode;
    cls.chr          = in_char;
    cls.is_backslash = (in_char == CHAR_BACKSLASH);
    cls.esc_class    = ESC_LIT;
    cls.esc_val      = in_char;
    case (in_char)
      8'h6e:   cls.esc_val = 8'h0a;
      8'h72:   cls.esc_val = 8'h0d;
      8'h74:   cls.esc_val = 8'h09;
      8'h30:   cls.esc_val = 8'h00;
      8'h5c, 8'h27, 8'h22: cls.esc_val = in_char;
      CHAR_HASH: cls.esc_class = ESC_HASH;
      8'h78:   cls.esc_class = ESC_HEX;
      default: cls.esc_class = ESC_BAD;
    endcase
    if (in_char inside {[8'h30:8'h39]}) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(in_char - 8'h30);
    end else if (in_char inside {[8'h61:8'h66]}) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(in_char - 8'h57);
    end else if (in_char inside {[8'h41:8'h46]}) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(in_char - 8'h37);
    end
  end

endmodule

>>> design/esd_back.sv
// Back end: the escape state machine that turns classified characters into results.
// Depends on esd_pkg for the classification and result records.
module esd_back
  import esd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       mark_enable,
  input  logic [7:0] marker_byte,
  input  logic       item_valid,
  input  class_t     cls,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_HEX1   = 3'd2;
  localparam logic [2:0] MODE_HEX2   = 3'd3;
  localparam logic [2:0] MODE_ERROR  = 3'd4;

  logic [2:0] mode;
  logic [2:0] mode_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;

  always_comb begin
    mode_next        = mode;
    high_nibble_next = high_nibble;
    res_valid        = 1'b0;
    res              = '0;
    if (cls.is_end) begin
      res_valid        = 1'b1;
      res.end_flag     = 1'b1;
      res.status       = (mode != MODE_NORMAL);
      mode_next        = MODE_NORMAL;
      high_nibble_next = '0;
    end else begin
      case (mode)
        MODE_NORMAL: begin
          if (cls.is_backslash) begin
            mode_next = MODE_ESC;
          end else begin
            res_valid      = 1'b1;
            res.byte_valid = 1'b1;
            res.out_byte   = cls.chr;
          end
        end
        MODE_ESC: begin
          mode_next = MODE_NORMAL;
          case (cls.esc_class)
            ESC_LIT: begin
              res_valid      = 1'b1;
              res.byte_valid = 1'b1;
              res.out_byte   = cls.esc_val;
            end
            ESC_HASH: begin
              res_valid      = 1'b1;
              res.byte_valid = 1'b1;
              res.out_byte   = mark_enable ? marker_byte : CHAR_HASH;
            end
            ESC_HEX: mode_next = MODE_HEX1;
            default: mode_next = MODE_ERROR;
          endcase
        end
        MODE_HEX1: begin
          if (cls.hex_ok) begin
            high_nibble_next = cls.hex_val;
            mode_next        = MODE_HEX2;
          end else begin
            mode_next = MODE_ERROR;
          end
        end
        MODE_HEX2: begin
          if (cls.hex_ok) begin
            mode_next      = MODE_NORMAL;
            res_valid      = 1'b1;
            res.byte_valid = 1'b1;
            res.out_byte   = {high_nibble, cls.hex_val};
          end else begin
            mode_next = MODE_ERROR;
          end
        end
        default: mode_next = MODE_ERROR;
      endcase
    end
    if (!item_valid) begin
      mode_next        = mode;
      high_nibble_next = high_nibble;
      res_valid        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      high_nibble <= '0;
    end else begin
      mode        <= mode_next;
      high_nibble <= high_nibble_next;
    end
  end

endmodule

>>> tb/tb_escape_sequence_decoder.sv
// Self-checking testbench for escape_sequence_decoder: directed and random character streams.
// A scoreboard class predicts the decoded bytes and end statuses and checks every transaction.
// Depends on esd_pkg and the escape_sequence_decoder design files.
module tb_escape_sequence_decoder
  import esd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LOW_G  = 8'h67;
  localparam logic [7:0] CH_LOW_Q  = 8'h71;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;

  localparam int IDLE_PCT    = 17;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [2:0] {
    DEC_NORMAL,
    DEC_ESCAPE,
    DEC_HEX_FIRST,
    DEC_HEX_SECOND,
    DEC_ERROR
  } decode_mode_t;

  class decode_scoreboard;
    result_t      pending[$];
    logic         mark_enable;
    logic [7:0]   marker_byte;
    decode_mode_t mode;
    logic [3:0]   high_nibble;
    int           errors;

    function new();
      mark_enable = 1'b0;
      marker_byte = 8'h00;
      mode        = DEC_NORMAL;
      high_nibble = 4'h0;
      errors      = 0;
    endfunction

    function void set_reg(logic index, logic [7:0] value);
      if (index == REG_MARK_ENABLE) begin
        mark_enable = value[0];
      end else begin
        marker_byte = value;
      end
    endfunction

    function logic [4:0] hex_digit(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, 4'(c - CH_ZERO)};
      if (c >= CH_LOW_A && c <= CH_LOW_F) return {1'b0, 4'(c - CH_LOW_A + 10)};
      if (c >= CH_UP_A && c <= CH_UP_F) return {1'b0, 4'(c - CH_UP_A + 10)};
      return 5'h10;
    endfunction

    function void expect_byte(logic [7:0] value);
      result_t r;
      r.byte_valid = 1'b1;
      r.out_byte   = value;
      r.end_flag   = 1'b0;
      r.status     = 1'b0;
      pending = {pending, r};
    endfunction

    function void note_item(logic op, logic [7:0] c);
      result_t    r;
      logic [4:0] digit;
      if (op == OP_END) begin
        r.byte_valid = 1'b0;
        r.out_byte   = 8'h00;
        r.end_flag   = 1'b1;
        r.status     = (mode != DEC_NORMAL);
        pending = {pending, r};
        mode        = DEC_NORMAL;
        high_nibble = 4'h0;
        return;
      end
      case (mode)
        DEC_NORMAL: begin
          if (c == CHAR_BACKSLASH) mode = DEC_ESCAPE;
          else expect_byte(c);
        end
        DEC_ESCAPE: begin
          mode = DEC_NORMAL;
          case (c)
            CH_N:           expect_byte(CH_LF);
            CH_R:           expect_byte(CH_CR);
            CH_T:           expect_byte(CH_TAB);
            CH_ZERO:        expect_byte(8'h00);
            CHAR_BACKSLASH: expect_byte(CHAR_BACKSLASH);
            CH_APOS:        expect_byte(CH_APOS);
            CH_DQUOTE:      expect_byte(CH_DQUOTE);
            CHAR_HASH:      expect_byte(mark_enable ? marker_byte : CHAR_HASH);
            CH_X:           mode = DEC_HEX_FIRST;
            default:        mode = DEC_ERROR;
          endcase
        end
        DEC_HEX_FIRST: begin
          digit = hex_digit(c);
          if (digit[4]) begin
            mode = DEC_ERROR;
          end else begin
            high_nibble = digit[3:0];
            mode        = DEC_HEX_SECOND;
          end
        end
        DEC_HEX_SECOND: begin
          digit = hex_digit(c);
          if (digit[4]) begin
            mode = DEC_ERROR;
          end else begin
            mode = DEC_NORMAL;
            expect_byte({high_nibble, digit[3:0]});
          end
        end
        default: mode = DEC_ERROR;
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected transaction %p", got));
        return;
      end
      want = pending.pop_front();
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("byte_valid %b, wanted %b", got.byte_valid, want.byte_valid));
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %h, wanted %h", got.out_byte, want.out_byte));
      if (got.end_flag !== want.end_flag)
        report($sformatf("end_flag %b, wanted %b", got.end_flag, want.end_flag));
      if (got.status !== want.status)
        report($sformatf("status %b, wanted %b", got.status, want.status));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic       opcode;
  logic [7:0] in_char;
  logic       empty;
  logic       pop;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic       end_flag;
  logic       status;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  decode_scoreboard sb;
  bit quiet;
  bit hold_request;
  int hold_left;
  int items_sent;
  int cycles;

  escape_sequence_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .in_char   (in_char),
    .empty     (empty),
    .pop       (pop),
    .byte_valid(byte_valid),
    .out_byte  (out_byte),
    .end_flag  (end_flag),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task send_item(input logic op, input logic [7:0] c);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    opcode  <= op;
    in_char <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(op, c);
    items_sent++;
  endtask

  task drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_config(input logic keep, input logic [7:0] marker);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MARK_ENABLE;
    cfg_data  <= {7'b0, keep};
    @(posedge clk);
    sb.set_reg(REG_MARK_ENABLE, {7'b0, keep});
    cfg_index <= REG_MARKER_BYTE;
    cfg_data  <= marker;
    @(posedge clk);
    sb.set_reg(REG_MARKER_BYTE, marker);
    cfg_we <= 1'b0;
  endtask

  function logic [7:0] pick_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 16) return CH_LOW_A + 8'(r - 10);
    return CH_UP_A + 8'(r - 16);
  endfunction

  function logic [7:0] pick_escape();
    case ($urandom_range(0, 8))
      0:       return CH_N;
      1:       return CH_R;
      2:       return CH_T;
      3:       return CH_ZERO;
      4:       return CHAR_BACKSLASH;
      5:       return CH_APOS;
      6:       return CH_DQUOTE;
      7:       return CHAR_HASH;
      default: return CH_X;
    endcase
  endfunction

  task send_random_group();
    int         kind;
    int         extra;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      send_item(OP_CHAR, 8'($urandom_range(0, 255)));
    end else if (kind < 75) begin
      c = pick_escape();
      send_item(OP_CHAR, CHAR_BACKSLASH);
      send_item(OP_CHAR, c);
      if (c == CH_X) begin
        send_item(OP_CHAR, pick_hex());
        send_item(OP_CHAR, pick_hex());
      end
    end else if (kind < 83) begin
      send_item(OP_END, 8'($urandom_range(0, 255)));
    end else if (kind < 93) begin
      send_item(OP_CHAR, CHAR_BACKSLASH);
      case ($urandom_range(0, 2))
        0: ;
        1: send_item(OP_CHAR, CH_X);
        default: begin
          send_item(OP_CHAR, CH_X);
          send_item(OP_CHAR, pick_hex());
        end
      endcase
      send_item(OP_CHAR, 8'($urandom_range(0, 255)));
      extra = $urandom_range(0, 3);
      repeat (extra) send_item(OP_CHAR, 8'($urandom_range(0, 255)));
    end else begin
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  task run_random_phase(input int count, input int quiet_count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      quiet = (items_sent - start < quiet_count);
      send_random_group();
    end
    quiet = 1'b0;
    send_item(OP_END, 8'($urandom_range(0, 255)));
    drain();
  endtask

  initial begin
    result_t got;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got.byte_valid = byte_valid;
        got.out_byte   = out_byte;
        got.end_flag   = end_flag;
        got.status     = status;
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !rst && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    sb        = new();
    rst       <= 1'b1;
    push      <= 1'b0;
    opcode    <= OP_CHAR;
    in_char   <= 8'h00;
    pop       <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MARK_ENABLE;
    cfg_data  <= 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_config(1'b1, 8'h80);
    send_item(OP_CHAR, 8'h00);
    send_item(OP_CHAR, 8'hff);
    send_item(OP_CHAR, CHAR_BACKSLASH);
    send_item(OP_CHAR, CH_N);
    send_item(OP_CHAR, CHAR_BACKSLASH);
    send_item(OP_CHAR, CH_DQUOTE);
    send_item(OP_CHAR, CHAR_BACKSLASH);
    send_item(OP_CHAR, CHAR_HASH);
    send_item(OP_CHAR, CHAR_BACKSLASH);
    send_item(OP_CHAR, CH_X);
    send_item(OP_CHAR, CH_LOW_A);
    send_item(OP_CHAR, CH_UP_F);
    send_item(OP_END, 8'h00);
    send_item(OP_CHAR, CHAR_BACKSLASH);
    send_item(OP_END, 8'hff);
    send_item(OP_CHAR, CHAR_BACKSLASH);
    send_item(OP_CHAR, CH_LOW_Q);
    send_item(OP_CHAR, CH_UP_Z);
    send_item(OP_END, 8'h00);
    send_item(OP_CHAR, CHAR_BACKSLASH);
    send_item(OP_CHAR, CH_X);
    send_item(OP_CHAR, CH_LOW_G);
    send_item(OP_END, 8'h00);
    drain();

    write_config(1'b1, 8'hff);
    run_random_phase(230, 0);

    write_config(1'b1, 8'h00);
    hold_request = 1'b1;
    run_random_phase(230, 0);

    write_config(1'b1, 8'($urandom_range(0, 255)));
    run_random_phase(250, 150);

    write_config(1'b0, 8'ha5);
    run_random_phase(230, 0);

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
